>>> hw/rtl/source_tokenizer_top_assert.svh
// Assertion macros for the source tokenizer RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset
`define STOK_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("source tokenizer check failed");
// Check that a trigger implies a condition at the next clock edge
`define STOK_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("source tokenizer check failed");
`else
`define STOK_ASSERT(lbl, clk, rst, cond)
`define STOK_ASSERT_NEXT(lbl, clk, rst, trig, cond)
`endif

`endif

>>> hw/rtl/stok_pkg.sv
// Shared types, token kind codes and character class helpers for the tokenizer.
// No dependencies.
`default_nettype none

package stok_pkg;

  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned LENGTH_BITS_DEF = 8;
  localparam int unsigned CFG_LINE_W      = 20;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned PREFIX_W        = 40;
  localparam int unsigned MAX_TOKENS      = 3;

  // Register byte addresses (bit 2 selects the register slot)
  localparam logic [APB_ADDR_W-1:0] REG_START_LINE = 3'd0;

  // Token kinds
  localparam logic [5:0] KIND_VAR       = 6'd0;
  localparam logic [5:0] KIND_PRINT     = 6'd1;
  localparam logic [5:0] KIND_IF        = 6'd2;
  localparam logic [5:0] KIND_ELSE      = 6'd3;
  localparam logic [5:0] KIND_FI        = 6'd4;
  localparam logic [5:0] KIND_LOOP      = 6'd5;
  localparam logic [5:0] KIND_DONE      = 6'd6;
  localparam logic [5:0] KIND_STEP      = 6'd7;
  localparam logic [5:0] KIND_FUN       = 6'd8;
  localparam logic [5:0] KIND_RET       = 6'd9;
  localparam logic [5:0] KIND_SYS       = 6'd10;
  localparam logic [5:0] KIND_ASSIGN    = 6'd11;
  localparam logic [5:0] KIND_ARROW     = 6'd12;
  localparam logic [5:0] KIND_PLUS      = 6'd13;
  localparam logic [5:0] KIND_PLUSPLUS  = 6'd14;
  localparam logic [5:0] KIND_MINUS     = 6'd15;
  localparam logic [5:0] KIND_MULTIPLY  = 6'd16;
  localparam logic [5:0] KIND_DIVISION  = 6'd17;
  localparam logic [5:0] KIND_LESS      = 6'd18;
  localparam logic [5:0] KIND_GREATER   = 6'd19;
  localparam logic [5:0] KIND_EQUAL     = 6'd20;
  localparam logic [5:0] KIND_NOT_EQ    = 6'd21;
  localparam logic [5:0] KIND_AND       = 6'd22;
  localparam logic [5:0] KIND_OR        = 6'd23;
  localparam logic [5:0] KIND_L_PAR     = 6'd24;
  localparam logic [5:0] KIND_R_PAR     = 6'd25;
  localparam logic [5:0] KIND_L_BRACKET = 6'd26;
  localparam logic [5:0] KIND_R_BRACKET = 6'd27;
  localparam logic [5:0] KIND_DOT       = 6'd28;
  localparam logic [5:0] KIND_COMMA     = 6'd29;
  localparam logic [5:0] KIND_SEMICOLON = 6'd30;
  localparam logic [5:0] KIND_NEWLN     = 6'd31;
  localparam logic [5:0] KIND_IDENT     = 6'd32;
  localparam logic [5:0] KIND_NUMBER    = 6'd33;
  localparam logic [5:0] KIND_FLOAT     = 6'd34;
  localparam logic [5:0] KIND_STRING    = 6'd35;
  localparam logic [5:0] KIND_EOF       = 6'd36;
  localparam logic [5:0] KIND_ERR       = 6'd37;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_BYTE  = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR  = 2'd2;
  localparam logic [1:0] ERR_OPEN_CMNT = 2'd3;

  // Message lengths reported by error tokens
  localparam int unsigned MSG_LEN_BAD_BYTE  = 24;
  localparam int unsigned MSG_LEN_OPEN_STR  = 19;
  localparam int unsigned MSG_LEN_OPEN_CMNT = 26;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_HOLD        = 4'd1,
    MODE_IDENT       = 4'd2,
    MODE_INT         = 4'd3,
    MODE_INT_DOT     = 4'd4,
    MODE_FRAC        = 4'd5,
    MODE_STRING      = 4'd6,
    MODE_LINE_CMNT   = 4'd7,
    MODE_BLOCK       = 4'd8,
    MODE_BLOCK_STAR  = 4'd9
  } mode_e;

  // Fixed-width part of one token
  typedef struct packed {
    logic [5:0] kind;
    logic [1:0] err;
    logic [7:0] bad;
  } tok_meta_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Single-byte punctuators; IDENT marks no match
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h2A:   k = KIND_MULTIPLY;
      8'h3C:   k = KIND_LESS;
      8'h3E:   k = KIND_GREATER;
      8'h3D:   k = KIND_EQUAL;
      8'h26:   k = KIND_AND;
      8'h7C:   k = KIND_OR;
      8'h28:   k = KIND_L_PAR;
      8'h29:   k = KIND_R_PAR;
      8'h5B:   k = KIND_L_BRACKET;
      8'h5D:   k = KIND_R_BRACKET;
      8'h2E:   k = KIND_DOT;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMICOLON;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  // Keyword match on the right-aligned identifier bytes; IDENT if none
  function automatic logic [5:0] kw_match(input logic [PREFIX_W-1:0] p,
                                          input logic [2:0] n);
    logic [5:0] k;
    k = KIND_IDENT;
    if (n == 3'd3 && p == 40'h0000766172) k = KIND_VAR;
    if (n == 3'd2 && p == 40'h0000006966) k = KIND_IF;
    if (n == 3'd2 && p == 40'h0000006669) k = KIND_FI;
    if (n == 3'd4 && p == 40'h00656C7365) k = KIND_ELSE;
    if (n == 3'd4 && p == 40'h006C6F6F70) k = KIND_LOOP;
    if (n == 3'd4 && p == 40'h00646F6E65) k = KIND_DONE;
    if (n == 3'd5 && p == 40'h7072696E74) k = KIND_PRINT;
    if (n == 3'd5 && p == 40'h6E65776C6E) k = KIND_NEWLN;
    if (n == 3'd3 && p == 40'h0000737973) k = KIND_SYS;
    if (n == 3'd4 && p == 40'h0073746570) k = KIND_STEP;
    if (n == 3'd3 && p == 40'h000066756E) k = KIND_FUN;
    if (n == 3'd3 && p == 40'h0000726574) k = KIND_RET;
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stok_scanner.sv
// Scanner core: holds the lexer state and turns one byte into up to three tokens.
// Depends on stok_pkg.
`default_nettype none

module stok_scanner
  import stok_pkg::*;
#(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   eoi_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_LINE_W-1:0]  cfg_line_i,
  input  wire logic [CFG_LINE_W-1:0]  start_line_i,
  output tok_meta_t                   tok_meta_o [MAX_TOKENS],
  output logic [LINE_BITS-1:0]        tok_line_o [MAX_TOKENS],
  output logic [LENGTH_BITS-1:0]      tok_len_o  [MAX_TOKENS],
  output logic [1:0]                  tok_cnt_o
);

  localparam int unsigned LEN_MAX = (1 << LENGTH_BITS) - 1;

  function automatic logic [LENGTH_BITS-1:0] sat_const(input int unsigned v);
    if (v > LEN_MAX) return LENGTH_BITS'(LEN_MAX);
    return LENGTH_BITS'(v);
  endfunction

  mode_e                   mode_q, mode_d;
  logic [7:0]              held_q, held_d;
  logic [LINE_BITS-1:0]    line_q, line_d;
  logic [LINE_BITS-1:0]    tsl_q, tsl_d;
  logic [LENGTH_BITS-1:0]  len_q, len_d;
  logic [PREFIX_W-1:0]     pfx_q, pfx_d;
  logic                    ovf_q, ovf_d;

  logic [LINE_BITS-1:0]    line_inc;
  logic [LENGTH_BITS:0]    len_add1, len_add2;
  logic [LENGTH_BITS-1:0]  len_inc1, len_inc2;
  logic                    id_char;
  tok_meta_t               held_meta;
  logic [LENGTH_BITS-1:0]  held_len;
  logic [5:0]              id_kind;
  logic [LENGTH_BITS-1:0]  id_len;
  logic [5:0]              sk;
  logic                    go_idle;
  logic [1:0]              cnt;

  // Shared helpers: line step, saturating length, pending token forms
  always_comb begin
    line_inc = line_q + LINE_BITS'(1);
    len_add1 = {1'b0, len_q} + (LENGTH_BITS + 1)'(1);
    len_add2 = {1'b0, len_q} + (LENGTH_BITS + 1)'(2);
    len_inc1 = len_add1[LENGTH_BITS] ? LENGTH_BITS'(LEN_MAX) : len_add1[LENGTH_BITS-1:0];
    len_inc2 = len_add2[LENGTH_BITS] ? LENGTH_BITS'(LEN_MAX) : len_add2[LENGTH_BITS-1:0];
    id_char  = is_alpha(byte_i) || is_digit(byte_i) || byte_i == CH_UNDER;
    sk       = single_kind(byte_i);

    held_len = sat_const(1);
    priority case (held_q)
      CH_SLASH: held_meta = '{kind: KIND_DIVISION, err: ERR_NONE, bad: 8'h00};
      CH_MINUS: held_meta = '{kind: KIND_MINUS, err: ERR_NONE, bad: 8'h00};
      CH_PLUS:  held_meta = '{kind: KIND_PLUS, err: ERR_NONE, bad: 8'h00};
      default: begin
        held_meta = '{kind: KIND_ERR, err: ERR_BAD_BYTE, bad: held_q};
        held_len  = sat_const(MSG_LEN_BAD_BYTE);
      end
    endcase

    if (ovf_q || len_q > LENGTH_BITS'(5)) id_kind = KIND_IDENT;
    else id_kind = kw_match(pfx_q, len_q[2:0]);
    id_len = (id_kind == KIND_NEWLN) ? sat_const(1) : len_q;
  end

  // Next state and emitted tokens
  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    line_d  = line_q;
    tsl_d   = tsl_q;
    len_d   = len_q;
    pfx_d   = pfx_q;
    ovf_d   = ovf_q;
    cnt     = 2'd0;
    go_idle = 1'b0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      tok_meta_o[i] = '0;
      tok_line_o[i] = line_q;
      tok_len_o[i]  = '0;
    end

    if (eoi_i) begin
      // Flush the pending token, then end-of-file, then clear
      unique case (mode_q)
        MODE_HOLD: begin
          tok_meta_o[cnt] = held_meta;
          tok_len_o[cnt]  = held_len;
          cnt = cnt + 2'd1;
        end
        MODE_IDENT: begin
          tok_meta_o[cnt] = '{kind: id_kind, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = id_len;
          cnt = cnt + 2'd1;
        end
        MODE_INT: begin
          tok_meta_o[cnt] = '{kind: KIND_NUMBER, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = len_q;
          cnt = cnt + 2'd1;
        end
        MODE_INT_DOT: begin
          tok_meta_o[cnt] = '{kind: KIND_NUMBER, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = len_q;
          cnt = cnt + 2'd1;
          tok_meta_o[cnt] = '{kind: KIND_DOT, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = sat_const(1);
          cnt = cnt + 2'd1;
        end
        MODE_FRAC: begin
          tok_meta_o[cnt] = '{kind: KIND_FLOAT, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = len_q;
          cnt = cnt + 2'd1;
        end
        MODE_STRING: begin
          tok_meta_o[cnt] = '{kind: KIND_ERR, err: ERR_OPEN_STR, bad: 8'h00};
          tok_line_o[cnt] = tsl_q;
          tok_len_o[cnt]  = sat_const(MSG_LEN_OPEN_STR);
          cnt = cnt + 2'd1;
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          tok_meta_o[cnt] = '{kind: KIND_ERR, err: ERR_OPEN_CMNT, bad: 8'h00};
          tok_line_o[cnt] = tsl_q;
          tok_len_o[cnt]  = sat_const(MSG_LEN_OPEN_CMNT);
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      tok_meta_o[cnt] = '{kind: KIND_EOF, err: ERR_NONE, bad: 8'h00};
      tok_len_o[cnt]  = '0;
      cnt = cnt + 2'd1;
      mode_d = MODE_IDLE;
      held_d = 8'h00;
      line_d = LINE_BITS'(start_line_i);
      tsl_d  = '0;
      len_d  = '0;
      pfx_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_HOLD: begin
          if (held_q == CH_SLASH && byte_i == CH_SLASH) begin
            mode_d = MODE_LINE_CMNT;
          end else if (held_q == CH_SLASH && byte_i == CH_STAR) begin
            mode_d = MODE_BLOCK;
            tsl_d  = line_q;
          end else if ((held_q == CH_COLON && byte_i == CH_EQUAL) ||
                       (held_q == CH_MINUS && byte_i == CH_GT) ||
                       (held_q == CH_BANG && byte_i == CH_EQUAL) ||
                       (held_q == CH_PLUS && byte_i == CH_PLUS)) begin
            priority case (held_q)
              CH_COLON: tok_meta_o[cnt].kind = KIND_ASSIGN;
              CH_MINUS: tok_meta_o[cnt].kind = KIND_ARROW;
              CH_BANG:  tok_meta_o[cnt].kind = KIND_NOT_EQ;
              default:  tok_meta_o[cnt].kind = KIND_PLUSPLUS;
            endcase
            tok_len_o[cnt] = sat_const(2);
            cnt = cnt + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            tok_meta_o[cnt] = held_meta;
            tok_len_o[cnt]  = held_len;
            cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (id_char) begin
            if (len_q >= LENGTH_BITS'(5)) ovf_d = 1'b1;
            pfx_d = {pfx_q[PREFIX_W-9:0], byte_i};
            len_d = len_inc1;
          end else begin
            tok_meta_o[cnt] = '{kind: id_kind, err: ERR_NONE, bad: 8'h00};
            tok_len_o[cnt]  = id_len;
            cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(byte_i)) begin
            len_d = len_inc1;
          end else if (byte_i == CH_DOT) begin
            mode_d = MODE_INT_DOT;
          end else begin
            tok_meta_o[cnt] = '{kind: KIND_NUMBER, err: ERR_NONE, bad: 8'h00};
            tok_len_o[cnt]  = len_q;
            cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          if (is_digit(byte_i)) begin
            mode_d = MODE_FRAC;
            len_d  = len_inc2;
          end else begin
            tok_meta_o[cnt] = '{kind: KIND_NUMBER, err: ERR_NONE, bad: 8'h00};
            tok_len_o[cnt]  = len_q;
            cnt = cnt + 2'd1;
            tok_meta_o[cnt] = '{kind: KIND_DOT, err: ERR_NONE, bad: 8'h00};
            tok_len_o[cnt]  = sat_const(1);
            cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(byte_i)) begin
            len_d = len_inc1;
          end else begin
            tok_meta_o[cnt] = '{kind: KIND_FLOAT, err: ERR_NONE, bad: 8'h00};
            tok_len_o[cnt]  = len_q;
            cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (byte_i == CH_QUOTE) begin
            tok_meta_o[cnt] = '{kind: KIND_STRING, err: ERR_NONE, bad: 8'h00};
            tok_line_o[cnt] = tsl_q;
            tok_len_o[cnt]  = len_q;
            cnt = cnt + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            if (byte_i == CH_LF) line_d = line_inc;
            len_d = len_inc1;
          end
        end
        MODE_LINE_CMNT: begin
          if (byte_i == CH_LF) go_idle = 1'b1;
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          if (mode_q == MODE_BLOCK_STAR && byte_i == CH_SLASH) begin
            mode_d = MODE_IDLE;
          end else begin
            if (byte_i == CH_LF) line_d = line_inc;
            mode_d = (byte_i == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // Scan the byte as the start of a new token
      if (go_idle) begin
        mode_d = MODE_IDLE;
        if (is_space(byte_i)) begin
          if (byte_i == CH_LF) line_d = line_inc;
        end else if (byte_i == CH_SLASH || byte_i == CH_COLON || byte_i == CH_MINUS ||
                     byte_i == CH_BANG || byte_i == CH_PLUS) begin
          mode_d = MODE_HOLD;
          held_d = byte_i;
        end else if (byte_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
          tsl_d  = line_q;
          len_d  = '0;
        end else if (is_alpha(byte_i) || byte_i == CH_UNDER) begin
          mode_d = MODE_IDENT;
          pfx_d  = PREFIX_W'(byte_i);
          len_d  = sat_const(1);
          ovf_d  = 1'b0;
        end else if (is_digit(byte_i)) begin
          mode_d = MODE_INT;
          len_d  = sat_const(1);
        end else if (sk != KIND_IDENT) begin
          tok_meta_o[cnt] = '{kind: sk, err: ERR_NONE, bad: 8'h00};
          tok_len_o[cnt]  = sat_const(1);
          cnt = cnt + 2'd1;
        end else begin
          tok_meta_o[cnt] = '{kind: KIND_ERR, err: ERR_BAD_BYTE, bad: byte_i};
          tok_len_o[cnt]  = sat_const(MSG_LEN_BAD_BYTE);
          cnt = cnt + 2'd1;
        end
      end
    end
    tok_cnt_o = cnt;
  end

  // Hold the scan state; a config write reloads the line counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= 8'h00;
      line_q <= LINE_BITS'(1);
      tsl_q  <= '0;
      len_q  <= '0;
      pfx_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_q <= LINE_BITS'(cfg_line_i);
      end else if (step_i) begin
        line_q <= line_d;
      end
      if (step_i) begin
        mode_q <= mode_d;
        held_q <= held_d;
        tsl_q  <= tsl_d;
        len_q  <= len_d;
        pfx_q  <= pfx_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/source_tokenizer_top.sv
// Top level of the streaming source tokenizer: APB register, token queue, output stage.
// Depends on stok_pkg, stok_scanner and source_tokenizer_top_assert.svh.
//
// Usage: source bytes enter on the s_axis channel, one byte per request, with
// s_axis_tuser high marking end of input (the byte is then ignored). Tokens
// leave on the m_axis channel; m_axis_tuser holds the token kind and
// m_axis_tlast marks the last token caused by one input request.
// The start_line register (APB address 0) loads the line counter at once; the user must
// write it only while the block is idle, which the block itself leaves unchecked.
// A token passes from the scanner through the token queue and the output register to m_axis.
// Throughput: one byte per cycle while m_axis_tready is high; a byte that yields
// several tokens (up to three) holds the input until the single output port has
// drained the three-entry token queue down to its last token.
// Reset clears the scan state, sets start_line to 1 and empties the queue and
// the output register. When the receiver stalls, the output register holds
// its token and one more byte can still be accepted into the queue; after
// that s_axis_tready drops until the queue drains.
`default_nettype none

`include "source_tokenizer_top_assert.svh"

module source_tokenizer_top
  import stok_pkg::*;
#(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int unsigned TDATA_W    = ((LINE_BITS + LENGTH_BITS + 10 + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] in_byte
  input  wire logic                  s_axis_tuser,   // [0] end_of_input
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,   // token_line, token_length, error_code, bad_byte
  output logic [5:0]                 m_axis_tuser,   // [5:0] token_kind
  output logic                       m_axis_tlast,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [CFG_LINE_W-1:0]   start_line_q;
  logic                    cfg_we;

  tok_meta_t               tok_meta [MAX_TOKENS];
  logic [LINE_BITS-1:0]    tok_line [MAX_TOKENS];
  logic [LENGTH_BITS-1:0]  tok_len  [MAX_TOKENS];
  logic [1:0]              tok_cnt;

  tok_meta_t               pend_meta_q [MAX_TOKENS];
  logic [LINE_BITS-1:0]    pend_line_q [MAX_TOKENS];
  logic [LENGTH_BITS-1:0]  pend_len_q  [MAX_TOKENS];
  logic                    pend_last_q [MAX_TOKENS];
  logic [1:0]              pend_cnt_q;

  tok_meta_t               out_meta_q;
  logic [LINE_BITS-1:0]    out_line_q;
  logic [LENGTH_BITS-1:0]  out_len_q;
  logic                    out_last_q;
  logic                    out_valid_q;

  logic                    in_acc;
  logic                    pop;

  // APB register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_START_LINE);
  assign prdata = (paddr[2] == REG_START_LINE[2]) ? APB_DATA_W'(start_line_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_line_q <= CFG_LINE_W'(1);
    end else if (cfg_we) begin
      start_line_q <= pwdata[CFG_LINE_W-1:0];
    end
  end

  // Handshake: take a request when the queue will be empty this cycle
  assign pop           = (pend_cnt_q != 2'd0) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (pend_cnt_q == 2'd0) || (pend_cnt_q == 2'd1 && pop);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  stok_scanner #(
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_acc),
    .byte_i       (s_axis_tdata),
    .eoi_i        (s_axis_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_line_i   (pwdata[CFG_LINE_W-1:0]),
    .start_line_i (start_line_q),
    .tok_meta_o   (tok_meta),
    .tok_line_o   (tok_line),
    .tok_len_o    (tok_len),
    .tok_cnt_o    (tok_cnt)
  );

  // Queue fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
    end else if (in_acc) begin
      pend_cnt_q <= tok_cnt;
    end else if (pop) begin
      pend_cnt_q <= pend_cnt_q - 2'd1;
    end
  end

  // Queue payload: load fresh tokens or advance one slot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        pend_meta_q[i] <= tok_meta[i];
        pend_line_q[i] <= tok_line[i];
        pend_len_q[i]  <= tok_len[i];
        pend_last_q[i] <= (2'(i) == tok_cnt - 2'd1);
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_TOKENS - 1; i++) begin
        pend_meta_q[i] <= pend_meta_q[i+1];
        pend_line_q[i] <= pend_line_q[i+1];
        pend_len_q[i]  <= pend_len_q[i+1];
        pend_last_q[i] <= pend_last_q[i+1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_meta_q <= pend_meta_q[0];
      out_line_q <= pend_line_q[0];
      out_len_q  <= pend_len_q[0];
      out_last_q <= pend_last_q[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_meta_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = TDATA_W'({out_meta_q.bad, out_meta_q.err, out_len_q, out_line_q});

  // Checks
  `STOK_ASSERT(a_queue_bound, clk_i, !rst_ni, pend_cnt_q <= 2'd3)
  `STOK_ASSERT(a_accept_empty, clk_i, !rst_ni, !in_acc || pend_cnt_q == 2'd0 || pop)
  `STOK_ASSERT_NEXT(a_pop_loads, clk_i, !rst_ni, pop, m_axis_tvalid)
  `STOK_ASSERT(a_eof_last, clk_i, !rst_ni, !(m_axis_tvalid && m_axis_tuser == KIND_EOF) || m_axis_tlast)

endmodule

`default_nettype wire
